### design/ad_envelope_table_generator_defines.svh
// assertion macros used by the envelope core
`ifndef AD_ENVELOPE_TABLE_GENERATOR_DEFINES_SVH
`define AD_ENVELOPE_TABLE_GENERATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ADENV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ADENV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/adenv_pkg.sv
`timescale 1ns / 1ps

package adenv_pkg;

    localparam int SETTING_W   = 5;
    localparam int LEVEL_W     = 10;
    localparam int ELAPSED_W   = 14;
    localparam int CURVE_IDX_W = 10;

    localparam int DEF_CURVE_DEPTH       = 200;
    localparam int DEF_ATTACK_UNIT_TICKS = 200;
    localparam int DEF_DECAY_UNIT_TICKS  = 600;

    localparam int CURVE_TABLE_LEN = 200;
    localparam int ROM_ADDR_W      = $clog2(CURVE_TABLE_LEN);

    localparam logic [LEVEL_W-1:0] ATTACK_TOP = 10'd1021;
    localparam logic [LEVEL_W-1:0] END_LEVEL  = 10'd1023;

    typedef struct packed {
        logic [SETTING_W-1:0] attack_setting;
        logic [SETTING_W-1:0] decay_setting;
        logic                 sync_on_note;
    } cfg_t;

    localparam logic [LEVEL_W-1:0] CURVE_ROM [CURVE_TABLE_LEN] = '{
        10'd0,    10'd15,   10'd30,   10'd44,   10'd59,   10'd73,   10'd87,   10'd101,
        10'd116,  10'd130,  10'd143,  10'd157,  10'd170,  10'd183,  10'd195,  10'd208,
        10'd220,  10'd233,  10'd245,  10'd257,  10'd267,  10'd279,  10'd290,  10'd302,
        10'd313,  10'd324,  10'd335,  10'd346,  10'd355,  10'd366,  10'd376,  10'd386,
        10'd397,  10'd405,  10'd415,  10'd425,  10'd434,  10'd443,  10'd452,  10'd462,
        10'd470,  10'd479,  10'd488,  10'd495,  10'd504,  10'd513,  10'd520,  10'd528,
        10'd536,  10'd544,  10'd552,  10'd559,  10'd567,  10'd573,  10'd581,  10'd589,
        10'd595,  10'd602,  10'd609,  10'd616,  10'd622,  10'd629,  10'd635,  10'd642,
        10'd648,  10'd654,  10'd660,  10'd666,  10'd672,  10'd677,  10'd683,  10'd689,
        10'd695,  10'd700,  10'd706,  10'd711,  10'd717,  10'd722,  10'd726,  10'd732,
        10'd736,  10'd741,  10'd746,  10'd751,  10'd756,  10'd760,  10'd765,  10'd770,
        10'd774,  10'd778,  10'd783,  10'd787,  10'd791,  10'd796,  10'd799,  10'd803,
        10'd808,  10'd811,  10'd815,  10'd818,  10'd823,  10'd826,  10'd830,  10'd834,
        10'd837,  10'd840,  10'd845,  10'd848,  10'd851,  10'd854,  10'd858,  10'd861,
        10'd864,  10'd866,  10'd869,  10'd873,  10'd876,  10'd879,  10'd881,  10'd885,
        10'd887,  10'd890,  10'd893,  10'd896,  10'd898,  10'd901,  10'd903,  10'd906,
        10'd909,  10'd911,  10'd913,  10'd916,  10'd918,  10'd920,  10'd923,  10'd925,
        10'd927,  10'd929,  10'd931,  10'd933,  10'd936,  10'd938,  10'd940,  10'd942,
        10'd944,  10'd946,  10'd948,  10'd950,  10'd952,  10'd954,  10'd955,  10'd957,
        10'd960,  10'd961,  10'd963,  10'd965,  10'd966,  10'd968,  10'd969,  10'd971,
        10'd973,  10'd975,  10'd976,  10'd977,  10'd979,  10'd980,  10'd981,  10'd983,
        10'd984,  10'd986,  10'd988,  10'd989,  10'd990,  10'd991,  10'd993,  10'd994,
        10'd995,  10'd996,  10'd997,  10'd999,  10'd1000, 10'd1002, 10'd1003, 10'd1004,
        10'd1005, 10'd1006, 10'd1007, 10'd1008, 10'd1009, 10'd1010, 10'd1012, 10'd1013,
        10'd1014, 10'd1014, 10'd1015, 10'd1016, 10'd1017, 10'd1018, 10'd1019, 10'd1020
    };

    // reads past the end of the table return the last entry
    function automatic logic [LEVEL_W-1:0] curve_at(input logic [CURVE_IDX_W-1:0] i);
        logic [ROM_ADDR_W-1:0] a;
        if (i >= CURVE_IDX_W'(CURVE_TABLE_LEN))
        begin
            a = ROM_ADDR_W'(CURVE_TABLE_LEN - 1);
        end
        else
        begin
            a = i[ROM_ADDR_W-1:0];
        end
        return CURVE_ROM[a];
    endfunction

endpackage

### design/adenv_tick_if.sv
`timescale 1ns / 1ps

interface adenv_tick_if;
    logic valid;
    logic ready;
    logic clock_level;
    logic note_changed;

    modport source (output valid, output clock_level, output note_changed, input ready);
    modport sink (input valid, input clock_level, input note_changed, output ready);
endinterface

### design/adenv_env_if.sv
`timescale 1ns / 1ps

interface adenv_env_if;
    logic       valid;
    logic       ready;
    logic [9:0] pwm_level;
    logic       running;

    modport source (output valid, output pwm_level, output running, input ready);
    modport sink (input valid, input pwm_level, input running, output ready);
endinterface

### design/adenv_regs.sv
`timescale 1ns / 1ps

module adenv_regs
    import adenv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    localparam logic [1:0] REG_ATTACK = 2'd0;
    localparam logic [1:0] REG_DECAY  = 2'd1;
    localparam logic [1:0] REG_SYNC   = 2'd2;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_ATTACK: cfg_next.attack_setting = pwdata[SETTING_W-1:0];
                REG_DECAY:  cfg_next.decay_setting  = pwdata[SETTING_W-1:0];
                REG_SYNC:   cfg_next.sync_on_note   = pwdata[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_setting <= SETTING_W'(1);
            cfg_reg.decay_setting  <= SETTING_W'(1);
            cfg_reg.sync_on_note   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ATTACK: prdata = 32'(cfg_reg.attack_setting);
            REG_DECAY:  prdata = 32'(cfg_reg.decay_setting);
            REG_SYNC:   prdata = 32'(cfg_reg.sync_on_note);
            default:    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/adenv_core.sv
`timescale 1ns / 1ps
`include "ad_envelope_table_generator_defines.svh"

module adenv_core
    import adenv_pkg::*;
#(
    parameter int CURVE_DEPTH       = DEF_CURVE_DEPTH,
    parameter int ATTACK_UNIT_TICKS = DEF_ATTACK_UNIT_TICKS,
    parameter int DECAY_UNIT_TICKS  = DEF_DECAY_UNIT_TICKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    adenv_tick_if.sink  tick,
    adenv_env_if.source env
);

    localparam int IDX_W   = $clog2(2 * CURVE_DEPTH);
    localparam int A_THR_W = SETTING_W + $clog2(ATTACK_UNIT_TICKS + 1);
    localparam int D_THR_W = SETTING_W + $clog2(DECAY_UNIT_TICKS + 1);
    localparam int AD_W    = (A_THR_W > D_THR_W) ? A_THR_W : D_THR_W;
    localparam int CMP_W   = (AD_W > ELAPSED_W) ? AD_W : ELAPSED_W;

    localparam logic [IDX_W-1:0]     DEPTH_IDX   = IDX_W'(CURVE_DEPTH);
    localparam logic [IDX_W-1:0]     END_IDX     = IDX_W'(2 * CURVE_DEPTH - 1);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    logic                 prev_clock_reg;
    logic [IDX_W-1:0]     phase_index_reg;
    logic                 active_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 out_valid_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 running_reg;

    logic                 out_valid_next;
    logic [IDX_W-1:0]     phase_index_next;
    logic                 active_next;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [LEVEL_W-1:0]   level_next;

    logic                 tick_acc;
    logic                 fire;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [IDX_W-1:0]     idx_fire;
    logic [ELAPSED_W-1:0] elapsed_fire;
    logic                 act_fire;
    logic [CMP_W-1:0]     attack_thr;
    logic [CMP_W-1:0]     decay_thr;
    logic [CMP_W-1:0]     thr_sel;
    logic                 advance;
    logic                 at_end;
    logic                 in_attack;
    logic [IDX_W-1:0]     curve_off;
    logic [LEVEL_W-1:0]   curve_val;

    assign tick_acc   = tick.valid && tick.ready;
    assign tick.ready = !out_valid_reg || env.ready;

    // a setting of zero gives a zero-tick threshold, same as a setting of one
    always_comb
    begin
        if (cfg.attack_setting == '0)
        begin
            attack_thr = '0;
        end
        else
        begin
            attack_thr = CMP_W'(cfg.attack_setting - SETTING_W'(1))
                * CMP_W'(ATTACK_UNIT_TICKS);
        end
        if (cfg.decay_setting == '0)
        begin
            decay_thr = '0;
        end
        else
        begin
            decay_thr = CMP_W'(cfg.decay_setting - SETTING_W'(1))
                * CMP_W'(DECAY_UNIT_TICKS);
        end
    end

    always_comb
    begin
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                   : elapsed_reg + ELAPSED_W'(1);
        if (cfg.sync_on_note)
        begin
            fire = tick.note_changed;
        end
        else
        begin
            fire = tick.clock_level && !prev_clock_reg;
        end

        // attack setting of one starts straight in the decay half
        if (fire)
        begin
            idx_fire     = (cfg.attack_setting == SETTING_W'(1)) ? DEPTH_IDX : '0;
            elapsed_fire = '0;
            act_fire     = 1'b1;
        end
        else
        begin
            idx_fire     = phase_index_reg;
            elapsed_fire = elapsed_inc;
            act_fire     = active_reg;
        end

        thr_sel = (idx_fire < DEPTH_IDX) ? attack_thr : decay_thr;
        advance = act_fire && (CMP_W'(elapsed_fire) >= thr_sel);

        if (advance)
        begin
            phase_index_next = idx_fire + IDX_W'(1);
            elapsed_next     = '0;
        end
        else
        begin
            phase_index_next = idx_fire;
            elapsed_next     = elapsed_fire;
        end

        at_end      = phase_index_next >= END_IDX;
        active_next = act_fire && !at_end;

        in_attack = phase_index_next < DEPTH_IDX;
        curve_off = in_attack ? phase_index_next : phase_index_next - DEPTH_IDX;
        curve_val = curve_at(CURVE_IDX_W'(curve_off));

        if (at_end)
        begin
            level_next = END_LEVEL;
        end
        else if (in_attack)
        begin
            level_next = ATTACK_TOP - curve_val;
        end
        else
        begin
            level_next = curve_val;
        end

        if (tick_acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (env.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clock_reg  <= 1'b0;
            phase_index_reg <= '0;
            active_reg      <= 1'b0;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (tick_acc)
            begin
                prev_clock_reg  <= tick.clock_level;
                phase_index_reg <= phase_index_next;
                active_reg      <= active_next;
                elapsed_reg     <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            level_reg   <= level_next;
            running_reg <= active_next;
        end
    end

    assign env.valid     = out_valid_reg;
    assign env.pwm_level = level_reg;
    assign env.running   = running_reg;

    `ADENV_ASSERT_NEXT(a_request_gives_result, clk, rst_n, tick_acc, env.valid, "accepted tick left no result")
    `ADENV_ASSERT_NOW(a_running_not_end_level, clk, rst_n, env.valid && env.running, env.pwm_level != END_LEVEL, "running result carries end level")
    `ADENV_ASSERT_NOW(a_index_in_range, clk, rst_n, 1'b1, phase_index_reg <= END_IDX, "phase index beyond end of envelope")
    `ADENV_ASSERT_NOW(a_active_before_end, clk, rst_n, active_reg, phase_index_reg != END_IDX, "envelope still active at end index")

endmodule

### design/ad_envelope_table_generator.sv
`timescale 1ns / 1ps
// channel  dir   handshake            payload
// tick     in    valid / ready        clock_level, note_changed
// env      out   valid / ready        pwm_level[9:0], running
// apb      in    psel/penable/pready  paddr[3:0], pwdata / prdata (32 bit)
//
// one tick a cycle: a tick is accepted whenever the result register is empty or being taken
// the result appears in the cycle after its tick, from the result register
// a single step leads from the state registers to the result register
// reset clears the envelope state and result valid, and sets the settings (attack 1, decay 1)
// a stall on env holds the result and blocks tick only while the result register is full

module ad_envelope_table_generator
    import adenv_pkg::*;
#(
    parameter int CURVE_DEPTH       = DEF_CURVE_DEPTH,
    parameter int ATTACK_UNIT_TICKS = DEF_ATTACK_UNIT_TICKS,
    parameter int DECAY_UNIT_TICKS  = DEF_DECAY_UNIT_TICKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    adenv_tick_if.sink  tick,
    adenv_env_if.source env,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;

    adenv_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adenv_core #(
        .CURVE_DEPTH       (CURVE_DEPTH),
        .ATTACK_UNIT_TICKS (ATTACK_UNIT_TICKS),
        .DECAY_UNIT_TICKS  (DECAY_UNIT_TICKS)
    ) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .tick  (tick),
        .env   (env)
    );

endmodule

### sim/ad_envelope_table_checker.sv
`timescale 1ns / 1ps

package adenv_check_pkg;

    typedef enum logic [3:0] {
        REG_ATTACK = 4'h0,
        REG_DECAY  = 4'h4,
        REG_SYNC   = 4'h8
    } reg_addr_e;

    typedef struct packed {
        logic [9:0] level;
        logic       running;
    } env_sample_t;

endpackage

module ad_envelope_table_checker
    import adenv_check_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    adenv_tick_if       tick,
    adenv_env_if        env,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    localparam int CURVE_LEN   = 200;
    localparam int ATTACK_UNIT = 200;
    localparam int DECAY_UNIT  = 600;
    localparam int LAST_STEP   = 2 * CURVE_LEN - 1;

    localparam logic [13:0] ELAPSED_TOP = 14'h3FFF;
    localparam logic [9:0]  PEAK_LEVEL  = 10'd1021;
    localparam logic [9:0]  DONE_LEVEL  = 10'd1023;

    localparam logic [9:0] CURVE_TAB [CURVE_LEN] = '{
        10'd0,    10'd15,   10'd30,   10'd44,   10'd59,   10'd73,   10'd87,   10'd101,
        10'd116,  10'd130,  10'd143,  10'd157,  10'd170,  10'd183,  10'd195,  10'd208,
        10'd220,  10'd233,  10'd245,  10'd257,  10'd267,  10'd279,  10'd290,  10'd302,
        10'd313,  10'd324,  10'd335,  10'd346,  10'd355,  10'd366,  10'd376,  10'd386,
        10'd397,  10'd405,  10'd415,  10'd425,  10'd434,  10'd443,  10'd452,  10'd462,
        10'd470,  10'd479,  10'd488,  10'd495,  10'd504,  10'd513,  10'd520,  10'd528,
        10'd536,  10'd544,  10'd552,  10'd559,  10'd567,  10'd573,  10'd581,  10'd589,
        10'd595,  10'd602,  10'd609,  10'd616,  10'd622,  10'd629,  10'd635,  10'd642,
        10'd648,  10'd654,  10'd660,  10'd666,  10'd672,  10'd677,  10'd683,  10'd689,
        10'd695,  10'd700,  10'd706,  10'd711,  10'd717,  10'd722,  10'd726,  10'd732,
        10'd736,  10'd741,  10'd746,  10'd751,  10'd756,  10'd760,  10'd765,  10'd770,
        10'd774,  10'd778,  10'd783,  10'd787,  10'd791,  10'd796,  10'd799,  10'd803,
        10'd808,  10'd811,  10'd815,  10'd818,  10'd823,  10'd826,  10'd830,  10'd834,
        10'd837,  10'd840,  10'd845,  10'd848,  10'd851,  10'd854,  10'd858,  10'd861,
        10'd864,  10'd866,  10'd869,  10'd873,  10'd876,  10'd879,  10'd881,  10'd885,
        10'd887,  10'd890,  10'd893,  10'd896,  10'd898,  10'd901,  10'd903,  10'd906,
        10'd909,  10'd911,  10'd913,  10'd916,  10'd918,  10'd920,  10'd923,  10'd925,
        10'd927,  10'd929,  10'd931,  10'd933,  10'd936,  10'd938,  10'd940,  10'd942,
        10'd944,  10'd946,  10'd948,  10'd950,  10'd952,  10'd954,  10'd955,  10'd957,
        10'd960,  10'd961,  10'd963,  10'd965,  10'd966,  10'd968,  10'd969,  10'd971,
        10'd973,  10'd975,  10'd976,  10'd977,  10'd979,  10'd980,  10'd981,  10'd983,
        10'd984,  10'd986,  10'd988,  10'd989,  10'd990,  10'd991,  10'd993,  10'd994,
        10'd995,  10'd996,  10'd997,  10'd999,  10'd1000, 10'd1002, 10'd1003, 10'd1004,
        10'd1005, 10'd1006, 10'd1007, 10'd1008, 10'd1009, 10'd1010, 10'd1012, 10'd1013,
        10'd1014, 10'd1014, 10'd1015, 10'd1016, 10'd1017, 10'd1018, 10'd1019, 10'd1020
    };

    logic [4:0]  attack_set;
    logic [4:0]  decay_set;
    logic        sync_set;
    logic        prev_clk;
    logic [8:0]  step;
    logic        live;
    logic [13:0] elapsed;

    env_sample_t envelope_q [$];
    int          err_count = 0;
    int          backlog   = 0;

    assign mismatches  = err_count;
    assign outstanding = backlog;

    function automatic int ticks_per_step(input logic [4:0] setting, input int unit);
        if (setting == 5'd0)
        begin
            return 0;
        end
        return (int'(setting) - 1) * unit;
    endfunction

    // one microsecond tick of the envelope, returns the level it shows
    function automatic env_sample_t advance_envelope(input logic clk_lvl, input logic note);
        env_sample_t r;
        int          limit;
        if (elapsed != ELAPSED_TOP)
        begin
            elapsed = elapsed + 14'd1;
        end
        if ((!sync_set && clk_lvl && !prev_clk) || (sync_set && note))
        begin
            step    = (attack_set == 5'd1) ? 9'(CURVE_LEN) : 9'd0;
            live    = 1'b1;
            elapsed = 14'd0;
        end
        prev_clk = clk_lvl;
        if (live)
        begin
            if (step < 9'(CURVE_LEN))
            begin
                limit = ticks_per_step(attack_set, ATTACK_UNIT);
            end
            else
            begin
                limit = ticks_per_step(decay_set, DECAY_UNIT);
            end
            if (int'(elapsed) >= limit)
            begin
                step    = step + 9'd1;
                elapsed = 14'd0;
            end
        end
        if (step < 9'(CURVE_LEN))
        begin
            r.level = PEAK_LEVEL - CURVE_TAB[step];
        end
        else if (step < 9'(LAST_STEP))
        begin
            r.level = CURVE_TAB[step - 9'(CURVE_LEN)];
        end
        else
        begin
            r.level = DONE_LEVEL;
            live    = 1'b0;
        end
        r.running = live;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        env_sample_t want;
        if (!rst_n)
        begin
            attack_set = 5'd1;
            decay_set  = 5'd1;
            sync_set   = 1'b0;
            prev_clk   = 1'b0;
            step       = 9'd0;
            live       = 1'b0;
            elapsed    = 14'd0;
            envelope_q.delete();
            backlog <= 0;
        end
        else
        begin
            // results leave only after their request, from the result register, so take them before predicting
            if (env.valid && env.ready)
            begin
                if (envelope_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, pwm_level %0d running %0b",
                             $time, env.pwm_level, env.running);
                    err_count++;
                end
                else
                begin
                    want = envelope_q.pop_front();
                    if (env.pwm_level !== want.level)
                    begin
                        $display("%0t: pwm_level mismatch, expected %0d, actual %0d",
                                 $time, want.level, env.pwm_level);
                        err_count++;
                    end
                    if (env.running !== want.running)
                    begin
                        $display("%0t: running mismatch, expected %0b, actual %0b",
                                 $time, want.running, env.running);
                        err_count++;
                    end
                end
            end
            if (tick.valid && tick.ready)
            begin
                envelope_q.push_back(advance_envelope(tick.clock_level, tick.note_changed));
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_addr_e'(paddr))
                    REG_ATTACK: attack_set = pwdata[4:0];
                    REG_DECAY:  decay_set  = pwdata[4:0];
                    REG_SYNC:   sync_set   = pwdata[0];
                    default:    ;
                endcase
            end
            backlog <= envelope_q.size();
        end
    end

endmodule

### sim/ad_envelope_table_generator_tb.sv
`timescale 1ns / 1ps

module ad_envelope_table_generator_tb;
    import adenv_check_pkg::*;

    localparam int  HOLD_OFF_CYCLES = 60;
    localparam int  RANDOM_PHASES   = 14;
    localparam int  PHASE_REQUESTS  = 110;
    localparam int  SETTLE_CYCLES   = 10;
    localparam time TIMEOUT_NS      = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;

    // shared between the stimulus and the result side
    logic calm         = 1'b0;
    int   stall_req    = 0;
    int   stall_served = 0;

    adenv_tick_if tick_ch ();
    adenv_env_if  env_ch ();

    ad_envelope_table_generator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .env     (env_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ad_envelope_table_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_ch),
        .env         (env_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // result side
    initial
    begin
        env_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (stall_req != stall_served)
            begin
                env_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                stall_served = stall_served + 1;
            end
            else if (!calm && $urandom_range(99) < 8)
            begin
                env_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                env_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_tick(input logic clk_lvl, input logic note);
        if (!calm && $urandom_range(99) < 8)
        begin
            tick_ch.valid        <= 1'b0;
            tick_ch.clock_level  <= 1'($urandom_range(1));
            tick_ch.note_changed <= 1'($urandom_range(1));
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.clock_level  <= clk_lvl;
        tick_ch.note_changed <= note;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_setting(input reg_addr_e addr, input logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {27'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [4:0] atk, input logic [4:0] dec, input logic sync);
        wait_for_drain();
        write_setting(REG_ATTACK, atk);
        write_setting(REG_DECAY, dec);
        write_setting(REG_SYNC, {4'($urandom), sync});
    endtask

    // mostly the fast settings
    function automatic logic [4:0] pick_setting();
        int r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 5'($urandom_range(1));
        end
        else if (r < 80)
        begin
            return 5'($urandom_range(2, 3));
        end
        return 5'($urandom_range(31));
    endfunction

    task automatic run_phase(input int count, input bit noisy);
        int   half_max;
        int   note_odds;
        int   left;
        logic lvl;
        half_max  = ($urandom_range(2) == 0) ? 4 : (($urandom_range(1) == 0) ? 40 : 400);
        note_odds = ($urandom_range(2) == 0) ? 5 : (($urandom_range(1) == 0) ? 50 : 500);
        lvl       = 1'($urandom_range(1));
        left      = $urandom_range(1, half_max);
        for (int k = 0; k < count; k++)
        begin
            if (noisy)
            begin
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            else
            begin
                if (left == 0)
                begin
                    lvl  = ~lvl;
                    left = $urandom_range(1, half_max);
                end
                left--;
                send_tick(lvl, $urandom_range(note_odds - 1) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= REG_ATTACK;
        pwdata               <= 32'd0;
        tick_ch.valid        <= 1'b0;
        tick_ch.clock_level  <= 1'b0;
        tick_ch.note_changed <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle level after reset, then the default no-attack envelope and a restart
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);

        // zero attack steps every tick; top decay never reaches its threshold
        apply_settings(5'd0, 5'd31, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        apply_settings(5'd31, 5'd0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_settings(pick_setting(), pick_setting(), 1'($urandom_range(1)));
            calm = (p == 3);
            if (p == 6)
            begin
                // long hold-off on the result side so the block backs up the requests
                stall_req = stall_req + 1;
            end
            run_phase(PHASE_REQUESTS, $urandom_range(99) < 15);
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/adenv_pkg.sv
design/adenv_tick_if.sv
design/adenv_env_if.sv
design/adenv_regs.sv
design/adenv_core.sv
design/ad_envelope_table_generator.sv
sim/ad_envelope_table_checker.sv
sim/ad_envelope_table_generator_tb.sv
